// ===== rtl/core/mtb_pkg.sv =====
package mtb_pkg;

	typedef struct packed {
		logic        command;
		logic [31:0] tick;
		logic [31:0] event_word;
	} req_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last;
		logic [31:0] track_length;
		logic [1:0]  error;
	} rsp_t;

	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_END   = 1'b1;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_TYPE = 2'd1;
	localparam logic [1:0] ERR_BACK = 2'd2;
	localparam logic [1:0] ERR_SAT  = 2'd3;

	localparam logic [7:0] TYPE_SHORT = 8'h00;
	localparam logic [7:0] TYPE_TEMPO = 8'h01;

	localparam logic [3:0] STATUS_PROG     = 4'hC;
	localparam logic [3:0] STATUS_PRESSURE = 4'hD;

	localparam logic [7:0] BYTE_META     = 8'hFF;
	localparam logic [7:0] BYTE_TEMPO    = 8'h51;
	localparam logic [7:0] BYTE_TEMPO_LN = 8'h03;
	localparam logic [7:0] BYTE_EOT      = 8'h2F;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] VLQ_CONT      = 8'h80;

	localparam int DELTA_W = 28;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_SHORT2,
		KIND_SHORT3,
		KIND_TEMPO,
		KIND_NONE,
		KIND_END
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [DELTA_W-1:0] delta;
		logic [1:0]         err;
		logic [23:0]        payload;
	} job_t;

endpackage

// ===== rtl/core/mtb_front.sv =====
module mtb_front import mtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	input  logic full,
	output logic push,
	output job_t job
);

	logic [31:0] prev_tick_q;
	logic [32:0] diff;
	logic        backwards;
	logic        saturated;
	logic [7:0]  ev_type;
	logic [1:0]  err;

	assign req_stall = full;
	assign push      = req_valid && !full;

	// borrow out of the subtract means the tick went backwards
	assign diff      = {1'b0, req.tick} - {1'b0, prev_tick_q};
	assign backwards = diff[32];
	assign saturated = |diff[31:DELTA_W];
	assign ev_type   = req.event_word[31:24];

	always_comb begin
		job.payload = req.event_word[23:0];
		job.delta   = '0;
		err         = ERR_OK;
		if (backwards) begin
			err = ERR_BACK;
		end else if (saturated) begin
			job.delta = '1;
			err       = ERR_SAT;
		end else begin
			job.delta = diff[DELTA_W-1:0];
		end
		case (ev_type)
			TYPE_SHORT: begin
				if (req.event_word[7:4] == STATUS_PROG ||
				    req.event_word[7:4] == STATUS_PRESSURE) begin
					job.kind = KIND_SHORT2;
				end else begin
					job.kind = KIND_SHORT3;
				end
			end
			TYPE_TEMPO: job.kind = KIND_TEMPO;
			default: begin
				job.kind = KIND_NONE;
				if (err == ERR_OK) begin
					err = ERR_TYPE;
				end
			end
		endcase
		job.err = err;
		if (req.command == CMD_END) begin
			job.kind  = KIND_END;
			job.delta = '0;
			job.err   = ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_tick_q <= '0;
		end else if (push) begin
			if (req.command == CMD_END) begin
				prev_tick_q <= '0;
			end else if (!backwards) begin
				prev_tick_q <= req.tick;
			end
		end
	end

endmodule

// ===== rtl/core/mtb_queue.sv =====
module mtb_queue import mtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t rd_job
);

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign rd_job    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/mtb_back.sv =====
module mtb_back import mtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic not_empty,
	input  job_t job,
	output logic pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic [3:0]  idx_q;
	logic [31:0] byte_count_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic [1:0]  vlq_top;
	logic [2:0]  vlq_len;
	logic [3:0]  msg_len;
	logic [3:0]  total;
	logic [3:0]  msg_idx;
	logic [1:0]  grp_sel;
	logic [6:0]  grp;
	logic        is_last;
	logic        advance;
	logic [7:0]  next_byte;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign advance = not_empty && (!rsp_valid_q || !rsp_stall);

	// index of the most significant non-empty 7-bit group
	always_comb begin
		if (job.delta[27:21] != '0) begin
			vlq_top = 2'd3;
		end else if (job.delta[20:14] != '0) begin
			vlq_top = 2'd2;
		end else if (job.delta[13:7] != '0) begin
			vlq_top = 2'd1;
		end else begin
			vlq_top = 2'd0;
		end
	end

	assign vlq_len = 3'(vlq_top) + 3'd1;

	always_comb begin
		case (job.kind)
			KIND_SHORT2: msg_len = 4'd2;
			KIND_SHORT3: msg_len = 4'd3;
			KIND_TEMPO:  msg_len = 4'd6;
			default:     msg_len = 4'd0;
		endcase
	end

	assign total   = (job.kind == KIND_END) ? 4'd4 : 4'(vlq_len) + msg_len;
	assign is_last = idx_q == total - 4'd1;
	assign msg_idx = idx_q - 4'(vlq_len);
	assign grp_sel = vlq_top - idx_q[1:0];

	always_comb begin
		case (grp_sel)
			2'd0:    grp = job.delta[6:0];
			2'd1:    grp = job.delta[13:7];
			2'd2:    grp = job.delta[20:14];
			default: grp = job.delta[27:21];
		endcase
	end

	always_comb begin
		next_byte = BYTE_ZERO;
		if (job.kind == KIND_END) begin
			case (idx_q[1:0])
				2'd1:    next_byte = BYTE_META;
				2'd2:    next_byte = BYTE_EOT;
				default: next_byte = BYTE_ZERO;
			endcase
		end else if (idx_q < 4'(vlq_len)) begin
			next_byte = {1'b0, grp};
			if (idx_q[1:0] != vlq_top) begin
				next_byte = next_byte | VLQ_CONT;
			end
		end else if (job.kind == KIND_TEMPO) begin
			case (msg_idx)
				4'd0:    next_byte = BYTE_META;
				4'd1:    next_byte = BYTE_TEMPO;
				4'd2:    next_byte = BYTE_TEMPO_LN;
				4'd3:    next_byte = job.payload[23:16];
				4'd4:    next_byte = job.payload[15:8];
				default: next_byte = job.payload[7:0];
			endcase
		end else begin
			case (msg_idx)
				4'd0:    next_byte = job.payload[7:0];
				4'd1:    next_byte = job.payload[15:8];
				default: next_byte = job.payload[23:16];
			endcase
		end
	end

	assign pop = advance && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			byte_count_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				rsp_valid_q <= 1'b1;
				if (is_last) begin
					idx_q <= '0;
					if (job.kind == KIND_END) begin
						byte_count_q <= '0;
					end else begin
						byte_count_q <= byte_count_q + 32'(total);
					end
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.out_byte     <= next_byte;
			rsp_q.last         <= is_last;
			rsp_q.error        <= job.err;
			rsp_q.track_length <= (job.kind == KIND_END && is_last) ?
			                      byte_count_q + 32'd4 : '0;
		end
	end

endmodule

// ===== rtl/core/mids_event_to_midi_track_bytes_top.sv =====
// Encodes time-sorted events into track bytes, one byte per transaction on the
// rsp side. Each req transaction is classified combinationally (tick
// difference, error, message kind) and queued; the serialiser then sends the
// delta as a 1 to 4 byte variable-length quantity followed by 0, 2, 3 or 6
// message bytes, so an event takes 1 to 10 bytes and an end of track 4. A new
// req is taken every cycle while the two-entry queue has room; an accepted req
// is written into a queue entry and its bytes are then registered in the
// byte-wide output register. error repeats on every byte of the item and last
// marks its final byte; track_length is valid only on the last byte of an end.
module mids_event_to_midi_track_bytes_top import mtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic push;
	logic pop;
	logic full;
	logic not_empty;
	job_t wr_job;
	job_t rd_job;

	mtb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.full      (full),
		.push      (push),
		.job       (wr_job)
	);

	mtb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_job    (rd_job)
	);

	mtb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.job       (rd_job),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
